[hw/rtl/float_box_placement_core_macros.svh]
// Assertion macros used by the checker file of the float placement block.
// Depends on nothing; included by the checker module.
`ifndef FLOAT_BOX_PLACEMENT_CORE_MACROS_SVH
`define FLOAT_BOX_PLACEMENT_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FBP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same check, also active during reset.
`define FBP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hw/rtl/fbp_pkg.sv]
// Package for the float box placement block: types, codes and constants.
// Depends on nothing; imported by every RTL module of the block except fbp_ram.
package fbp_pkg;
  localparam int MaxFloatsDef = 16;
  // Width of every signed fixed point coordinate.
  localparam int CB = 24;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_PLACE  = 2'd2;

  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;
  localparam logic [1:0] SIDE_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic CFG_LEFT  = 1'b0;
  localparam logic CFG_RIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [1:0]          side;
    logic signed [CB-1:0] pos_x;
    logic signed [CB-1:0] pos_y;
    logic [CB-2:0]       size_w;
    logic [CB-2:0]       size_h;
    logic signed [CB-1:0] pad_l;
    logic signed [CB-1:0] pad_r;
    logic signed [CB-1:0] pad_t;
    logic signed [CB-1:0] pad_b;
  } in_word_t;

  typedef struct packed {
    logic signed [CB-1:0] place_x;
    logic signed [CB-1:0] place_y;
    logic signed [CB-1:0] margin_x;
    logic signed [CB-1:0] margin_y;
    logic signed [CB-1:0] margin_width;
    logic signed [CB-1:0] margin_height;
    logic signed [CB-1:0] band_left;
    logic signed [CB-1:0] band_right;
    logic signed [CB-1:0] band_clear_y;
    logic                 band_overlap;
    logic [1:0]           status;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // capture input word
    logic do_insert;   // write table entry from input word
    logic do_clear;    // empty the table
    logic scan_start;  // reset band accumulators
    logic scan_step;   // fold one read table entry into band
    logic move_down;   // move float_y to clear_y
    logic finish;      // compute result word
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic table_full;
    logic scan_last;
    logic keep_moving;
  } dp_stat_t;

  // Saturate an exact value (CB+4 bits wide) to CB bits.
  function automatic logic signed [CB-1:0] sat_c(input logic signed [CB+3:0] v,
                                                  output logic f);
    logic signed [CB+3:0] mx;
    logic signed [CB+3:0] mn;
    mx = (CB+4)'((64'sd1 <<< (CB-1)) - 64'sd1);
    mn = -mx - (CB+4)'(1);
    f = 1'b0;
    if (v > mx) begin
      f = 1'b1;
      sat_c = mx[CB-1:0];
    end else if (v < mn) begin
      f = 1'b1;
      sat_c = mn[CB-1:0];
    end else begin
      sat_c = v[CB-1:0];
    end
  endfunction
endpackage

[hw/rtl/fbp_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module fbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/fbp_datapath.sv]
// Datapath of the float placement block: float table, band scan and result.
// Depends on fbp_pkg and fbp_ram.
module fbp_datapath
  import fbp_pkg::*;
#(
  parameter int MAX_FLOATS = MaxFloatsDef
) (
  input  logic            clk,
  input  logic            rst,
  input  dp_cmd_t         cmd,
  input  in_word_t        in_word,
  input  logic signed [CB-1:0] cfg_left,
  input  logic signed [CB-1:0] cfg_right,
  output dp_stat_t        stat,
  output out_word_t       result
);
  localparam int AW = $clog2(MAX_FLOATS);
  localparam int NW = $clog2(MAX_FLOATS + 1);
  localparam int EW = CB + 4;
  localparam int RW = 3 * CB + 2;

  in_word_t             req;
  logic [NW-1:0]        count;
  logic [NW-1:0]        rd_idx;
  logic                 rd_valid;
  logic signed [CB-1:0] fy;
  logic signed [EW-1:0] th;
  logic signed [EW-1:0] need;
  logic signed [CB-1:0] b_left, b_right, b_clear;
  logic                 b_over;
  logic                 sat_flag;

  logic [1:0]           side_n;
  logic signed [CB-1:0] ins_bottom, ins_edge, fy0;
  logic                 f_ins_b, f_ins_e, f_fy0;
  logic [1:0]           ins_status;
  logic [RW-1:0]        wdata, rdata;
  logic signed [CB-1:0] e_top, e_bot, e_edge;
  logic [1:0]           e_side;
  logic                 hit;
  logic signed [CB-1:0] fl_right;

  assign side_n = (in_word.side == SIDE_RSVD) ? SIDE_NONE : in_word.side;
  always_comb begin
    ins_bottom = sat_c(EW'(in_word.pos_y) + EW'({1'b0, in_word.size_h}), f_ins_b);
  end
  always_comb begin
    logic signed [CB-1:0] t;
    t = sat_c(EW'(in_word.pos_x) + EW'({1'b0, in_word.size_w}), f_ins_e);
    unique case (side_n)
      SIDE_LEFT:  ins_edge = t;
      SIDE_RIGHT: begin ins_edge = in_word.pos_x; f_ins_e = 1'b0; end
      default:    begin ins_edge = '0; f_ins_e = 1'b0; end
    endcase
  end
  always_comb begin
    fy0 = sat_c(EW'(req.pos_y) + EW'(req.pad_t), f_fy0);
  end
  assign wdata = {in_word.pos_y, ins_bottom, ins_edge, side_n};
  assign ins_status = stat.table_full ? ST_FULL :
                      ((f_ins_b || f_ins_e) ? ST_SAT : ST_OK);

  fbp_ram #(.WIDTH(RW), .DEPTH(MAX_FLOATS)) u_table (
    .clk  (clk),
    .we   (cmd.do_insert && !stat.table_full),
    .waddr(count[AW-1:0]),
    .wdata(wdata),
    .raddr(rd_idx[AW-1:0]),
    .rdata(rdata)
  );

  assign e_top  = rdata[RW-1 -: CB];
  assign e_bot  = rdata[RW-1-CB -: CB];
  assign e_edge = rdata[RW-1-2*CB -: CB];
  assign e_side = rdata[1:0];
  assign hit = rd_valid && (fy < e_bot) && ((EW'(fy) + th) > EW'(e_top));

  assign stat.table_full  = (count >= NW'(MAX_FLOATS));
  assign stat.scan_last   = !rd_valid && (rd_idx >= count);
  assign fl_right = (b_right < b_left) ? b_left : b_right;
  assign stat.keep_moving = b_over && ((EW'(fl_right) - EW'(b_left)) < need) && (b_clear > fy);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_clear) begin
      count <= '0;
    end else if (cmd.do_insert && !stat.table_full) begin
      count <= count + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    logic fa, fb, fc, fd, fe, ff;
    logic signed [CB-1:0] fx, mx, my, mw, mh;
    out_word_t zw;
    if (cmd.load) begin
      // Every word but a place word answers with zero fields and a status.
      zw = '0;
      if (in_word.req_type == REQ_INSERT) zw.status = ins_status;
      req <= in_word;
      sat_flag <= 1'b0;
      result <= zw;
    end
    if (cmd.scan_start) begin
      if (!cmd.move_down) begin
        fy <= fy0;
        sat_flag <= f_fy0;
        th <= EW'({1'b0, req.size_h}) + EW'(req.pad_t) + EW'(req.pad_b);
        need <= EW'({1'b0, req.size_w}) + EW'(req.pad_l) + EW'(req.pad_r);
        b_clear <= fy0;
      end else begin
        fy <= b_clear;
      end
      b_left <= cfg_left;
      b_right <= cfg_right;
      b_over <= 1'b0;
      rd_idx <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_valid <= (rd_idx < count);
      if (rd_idx < count) rd_idx <= rd_idx + NW'(1);
      if (hit) begin
        b_over <= 1'b1;
        if (e_bot > b_clear) b_clear <= e_bot;
        if (e_side == SIDE_LEFT && e_edge > b_left) b_left <= e_edge;
        if (e_side == SIDE_RIGHT && e_edge < b_right) b_right <= e_edge;
      end
    end
    if (cmd.finish) begin
      unique case (req.side)
        SIDE_LEFT:  fx = sat_c(EW'(b_left) + EW'(req.pad_l), fa);
        SIDE_RIGHT: fx = sat_c(EW'(fl_right) - EW'(req.pad_r)
                               - EW'({1'b0, req.size_w}), fa);
        default:    begin fx = cfg_left; fa = 1'b0; end
      endcase
      mx = sat_c(EW'(fx) - EW'(req.pad_l), fb);
      my = sat_c(EW'(fy) - EW'(req.pad_t), fc);
      mw = sat_c(need, fd);
      mh = sat_c(th, fe);
      ff = sat_flag;
      result.place_x <= fx;
      result.place_y <= fy;
      result.margin_x <= mx;
      result.margin_y <= my;
      result.margin_width <= mw;
      result.margin_height <= mh;
      result.band_left <= b_left;
      result.band_right <= fl_right;
      result.band_clear_y <= b_clear;
      result.band_overlap <= b_over;
      result.status <= (fa || fb || fc || fd || fe || ff) ? ST_SAT : ST_OK;
    end
  end
endmodule

[hw/rtl/fbp_ctrl.sv]
// Controller state machine of the float placement block.
// Depends on fbp_pkg.
module fbp_ctrl
  import fbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic [1:0] req_type,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_START, S_SCAN, S_DECIDE, S_FINISH} state_t;
  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.load = accept;
    cmd.do_insert = accept && (req_type == REQ_INSERT);
    cmd.do_clear  = accept && (req_type == REQ_CLEAR);
    cmd.scan_start = (state == S_START) || (state == S_DECIDE && stat.keep_moving);
    cmd.move_down = (state == S_DECIDE);
    cmd.scan_step = (state == S_SCAN);
    cmd.finish = (state == S_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_type == REQ_PLACE) begin
              state <= S_START;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_START: state <= S_SCAN;
        S_SCAN: if (stat.scan_last) state <= S_DECIDE;
        S_DECIDE: state <= stat.keep_moving ? S_SCAN : S_FINISH;
        S_FINISH: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/float_box_placement_core.sv]
// Top level of the float box placement block.
// Depends on fbp_pkg, fbp_ctrl, fbp_datapath and fbp_ram.
//
// Usage: words arrive on the in channel (in_valid/in_ready, payload in_data)
// and one result word per input word leaves on the out channel
// (out_valid/out_ready, payload out_data). The left content edge (index 0)
// and the right content edge (index 1) are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no word is in
// flight; the block itself does not enforce this. For insert, clear and
// unused request words the result is valid the cycle after acceptance. A
// place word scans the float table one entry per cycle through the table
// memory's single registered read port. Each pass runs the scan state and
// then a decision state; with N stored floats the box moves down at most N
// times, so P passes with P <= N+1 are made. The start state, the passes and
// the finish state all come before the result is valid.
// One word is in flight at a time: in_ready drops from acceptance until the
// result has been taken, so a stalled receiver simply holds out_data steady.
// Reset empties the float table (count zero), clears both content edges and
// drops out_valid. Table contents are not cleared; entries beyond the count
// are never used.
module float_box_placement_core
  import fbp_pkg::*;
#(
  parameter int MAX_FLOATS = MaxFloatsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CB-1:0]        cfg_data
);
  logic signed [CB-1:0] left_edge, right_edge;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The configuration registers, written with no handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge <= '0;
      right_edge <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEFT) left_edge <= cfg_data;
      if (cfg_index == CFG_RIGHT) right_edge <= cfg_data;
    end
  end

  fbp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .req_type(in_data.req_type),
    .stat(stat), .cmd(cmd)
  );

  fbp_datapath #(.MAX_FLOATS(MAX_FLOATS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_data),
    .cfg_left(left_edge), .cfg_right(right_edge),
    .stat(stat), .result(out_data)
  );
endmodule

[hw/rtl/fbp_checker.sv]
// Port-level checker for the float placement block, bound to the top level.
// Depends on fbp_pkg and the macros header.
`include "float_box_placement_core_macros.svh"
module fbp_checker
  import fbp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  `FBP_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")
  `FBP_ASSERT(a_one, clk, rst, out_valid |-> !in_ready, "new word taken while result pending")
  `FBP_ASSERT(a_busy, clk, rst, in_valid && in_ready |=> !in_ready, "input ready right after a word")
  `FBP_ASSERT(a_band, clk, rst, out_valid |-> out_data.band_right >= out_data.band_left, "inverted band")
  `FBP_ASSERT_ALWAYS(a_rst, clk, rst |=> !out_valid, "result valid after reset")
endmodule

bind float_box_placement_core fbp_checker u_fbp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
